### design/lkv_pkg.sv
package lkv_pkg;

    localparam int LKV_ENTRIES   = 16;
    localparam int LKV_KEY_W     = 32;
    localparam int LKV_VAL_W     = 32;
    localparam int LKV_CAP_W     = 5;
    localparam logic [LKV_CAP_W-1:0] LKV_CAP_RESET = 5'd16;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;    // latch the incoming word
        logic lookup;  // compare key against all entries, register match
        logic update;  // apply recency, eviction, insert and memory access
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_put;
        logic out_busy;
    } t_dp_stat;

endpackage

### design/lkv_ram.sv
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lkv_ctrl.sv
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lkv_pkg::t_dp_stat i_stat,
    output lkv_pkg::t_dp_cmd  o_cmd
);

    import lkv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                // a get holds here until the result register is free
                if (i_stat.req_put || !i_stat.out_busy) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                o_in_ready   = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOOKUP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/lkv_dp.sv
module lkv_dp #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lkv_pkg::t_dp_cmd               i_cmd,
    output lkv_pkg::t_dp_stat              o_stat,
    input  logic                           i_req_type,
    input  logic [lkv_pkg::LKV_KEY_W-1:0]  i_key,
    input  logic [lkv_pkg::LKV_VAL_W-1:0]  i_value,
    input  logic                           i_cfg_we,
    input  logic [lkv_pkg::LKV_CAP_W-1:0]  i_cfg_wdata,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_found,
    output logic [lkv_pkg::LKV_VAL_W-1:0]  o_read_value
);

    import lkv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = IW + 1;

    // request word
    t_req                 r_req;
    logic [LKV_KEY_W-1:0] r_key;
    logic [LKV_VAL_W-1:0] r_val;

    // entry state
    logic [ENTRIES-1:0]   r_valid;
    logic [LKV_KEY_W-1:0] r_keys [ENTRIES];
    logic [IW-1:0]        r_rank [ENTRIES];
    logic [LW-1:0]        r_live;
    logic [LKV_CAP_W-1:0] r_capacity;

    // lookup result
    logic                 r_hit;
    logic [IW-1:0]        r_idx;

    // result path
    logic                 r_load;
    logic                 r_load_hit;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [LKV_VAL_W-1:0] r_out_data;

    logic [ENTRIES-1:0]   match;
    logic                 match_any;
    logic [IW-1:0]        match_idx;

    logic [LW-1:0]        cap_eff;
    logic [LW-1:0]        cap_m1;
    logic [IW-1:0]        hit_rank;
    logic [IW-1:0]        touch_rank [ENTRIES];
    logic [ENTRIES-1:0]   keep;
    logic                 free_ok;
    logic [IW-1:0]        free_idx;
    logic                 is_put;
    logic                 do_insert;

    logic [ENTRIES-1:0]   n_valid;
    logic [IW-1:0]        n_rank [ENTRIES];
    logic [LW-1:0]        n_live;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic                 ram_re;
    logic [LKV_VAL_W-1:0] ram_rdata;

    assign cap_eff = (32'(r_capacity) > 32'(ENTRIES)) ? LW'(ENTRIES) : LW'(r_capacity);
    assign cap_m1  = cap_eff - LW'(1);
    assign is_put  = (r_req == REQ_PUT);

    // parallel key compare
    always_comb begin
        match_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_keys[i] == r_key);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_idx = IW'(i);
            end
        end
        match_any = |match;
    end

    // recency, eviction and insert
    always_comb begin
        hit_rank  = r_rank[r_idx];
        free_ok   = 1'b0;
        free_idx  = '0;
        n_valid   = r_valid;
        n_live    = r_live;
        do_insert = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (IW'(i) == r_idx) begin
                touch_rank[i] = '0;
            end else if (r_rank[i] < hit_rank) begin
                touch_rank[i] = r_rank[i] + IW'(1);
            end else begin
                touch_rank[i] = r_rank[i];
            end
            // before an insert, keep only ranks below capacity minus one
            keep[i] = r_valid[i] && (cap_eff != '0) && ({1'b0, r_rank[i]} < cap_m1);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!keep[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
        if (i_cmd.update && r_hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                n_rank[i] = touch_rank[i];
                if (is_put) begin
                    n_valid[i] = r_valid[i] && ({1'b0, touch_rank[i]} < cap_eff);
                end
            end
            if (is_put && (r_live > cap_eff)) begin
                n_live = cap_eff;
            end
        end else if (i_cmd.update && is_put) begin
            n_valid = keep;
            if (cap_eff == '0) begin
                n_live = '0;
            end else begin
                n_live = ((r_live > cap_m1) ? cap_m1 : r_live) + LW'(1);
                do_insert = free_ok;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (keep[i]) begin
                        n_rank[i] = r_rank[i] + IW'(1);
                    end
                end
                n_rank[free_idx]  = '0;
                n_valid[free_idx] = free_ok;
            end
        end
    end

    assign ram_we    = i_cmd.update && is_put && (r_hit || do_insert);
    assign ram_waddr = r_hit ? r_idx : free_idx;
    assign ram_re    = i_cmd.update && !is_put && r_hit;

    lkv_ram #(
        .WIDTH (LKV_VAL_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= t_req'(i_req_type);
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_cmd.lookup) begin
            r_hit <= match_any;
            r_idx <= match_idx;
        end
        if (i_cmd.update) begin
            r_rank <= n_rank;
        end
        if (i_cmd.update && do_insert) begin
            r_keys[free_idx] <= r_key;
        end
        if (r_load) begin
            r_out_found <= r_load_hit;
            r_out_data  <= r_load_hit ? ram_rdata : '1;
        end
        r_load_hit <= r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_live      <= '0;
            r_capacity  <= LKV_CAP_RESET;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                r_valid <= n_valid;
                r_live  <= n_live;
            end
            // every get gives one word, loaded the cycle after update
            r_load <= i_cmd.update && !is_put;
            if (r_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req_put  = is_put;
    assign o_stat.out_busy = r_out_valid || r_load;

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_data;

endmodule

### design/lru_key_value_cache.sv
// a get word passes through accept, key compare, recency update with value read,
// then the result register before it shows on the master side
// each request runs key compare, then update; the next word can be accepted during
// the update; a get waits in compare until an earlier get's word is loaded and taken
// reset: synchronous, active low; clears the valid map and live count, sets
// capacity to 16 and empties the result register
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             s_axis_tvalid,
    output logic                                             s_axis_tready,
    // key [31:0], value [63:32]
    input  logic [lkv_pkg::LKV_KEY_W+lkv_pkg::LKV_VAL_W-1:0] s_axis_tdata,
    // req_type [0]
    input  logic                                             s_axis_tuser,
    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    // read_value [31:0]
    output logic [lkv_pkg::LKV_VAL_W-1:0]                    m_axis_tdata,
    // found [0]
    output logic                                             m_axis_tuser,
    input  logic                                             i_cfg_we,
    input  logic [lkv_pkg::LKV_CAP_W-1:0]                    i_cfg_wdata
);

    import lkv_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (s_axis_tuser),
        .i_key        (s_axis_tdata[LKV_KEY_W-1:0]),
        .i_value      (s_axis_tdata[LKV_KEY_W+LKV_VAL_W-1:LKV_KEY_W]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_found      (m_axis_tuser),
        .o_read_value (m_axis_tdata)
    );

endmodule

### design/lkv_checker.sv
module lkv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lkv_pkg::LKV_VAL_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a miss always reports all ones
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '1))
        else $error("miss without all-ones value");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // the key compare cycle takes no new word
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted during key compare");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
